/* rtl/core/json_header_doctype_detector_macros.svh */
// Assertion macros shared by the JSON header doctype detector RTL.
// Each macro expects clk_i and rst_ni in the scope that uses it.
`ifndef JSON_HEADER_DOCTYPE_DETECTOR_MACROS_SVH
`define JSON_HEADER_DOCTYPE_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JHDD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JHDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/jhdd_pkg.sv */
// Types, constants and character helpers of the JSON header doctype detector.
// Used by every module of the block; depends on nothing.
package jhdd_pkg;

  localparam int unsigned BufDepth   = 32;
  localparam int unsigned LenW       = $clog2(BufDepth + 1);
  localparam int unsigned AddrW      = $clog2(BufDepth);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharLBrace = 8'h7B;
  localparam logic [7:0] CharRBrace = 8'h7D;
  localparam logic [7:0] CharColon  = 8'h3A;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharUscore = 8'h5F;

  localparam int unsigned DoctypeLen  = 7;
  localparam int unsigned EncodingLen = 8;

  typedef enum logic [2:0] {
    StUndecided = 3'd0,
    StNotJson   = 3'd1,
    StNoDoc     = 3'd2,
    StDoctype   = 3'd3,
    StSyntax    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PsStart,
    PsHdr,
    PsSkeyDash,
    PsSkey,
    PsSeekAssign,
    PsAssign,
    PsIkey,
    PsIval,
    PsSval,
    PsSeekDelim,
    PsDone
  } parse_state_e;

  typedef enum logic [1:0] {
    KindNone,
    KindDoctype,
    KindEncoding
  } key_kind_e;

  typedef enum logic {
    BkIdle,
    BkBurst
  } back_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] value_byte;
    logic       value_valid;
    logic       last_of_run;
    logic       value_truncated;
  } out_item_t;

  typedef struct packed {
    logic            burst;
    status_e         status;
    logic [LenW-1:0] len;
    logic            trunc;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (to_lower(c) inside {[8'h61:8'h7A]}) || (c == CharUscore);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c <= CharSpace;
  endfunction

  function automatic logic [7:0] doctype_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "d";
      3'd1: r = "o";
      3'd2: r = "c";
      3'd3: r = "t";
      3'd4: r = "y";
      3'd5: r = "p";
      3'd6: r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] encoding_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "e";
      3'd1: r = "n";
      3'd2: r = "c";
      3'd3: r = "o";
      3'd4: r = "d";
      3'd5: r = "i";
      3'd6: r = "n";
      3'd7: r = "g";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/jhdd_front.sv */
// Front end of the JSON header doctype detector: header recognizer, key matching,
// value capture writes and result commands. Depends on jhdd_pkg and the macro header.
`include "json_header_doctype_detector_macros.svh"

module jhdd_front import jhdd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o,
  output mem_wr_t  mem_wr_o,
  input  logic     burst_done_i
);

  parse_state_e    state_q, state_d, st;
  logic [7:0]      quote_q, quote_d, qc;
  logic [7:0]      prev_q, prev_d, prev;
  logic            esc_q, esc_d, esc;
  key_kind_e       kind_q, kind_d, kk;
  logic [LenW-1:0] len_q, len_d, ln;
  logic            ovf_q, ovf_d, ov;
  status_e         verdict_q, verdict_d, vd;
  logic            dok_q, dok_d, dok;
  logic            eok_q, eok_d, eok;
  logic            burst_out_q, burst_out_d;

  logic [7:0] c;
  logic       accept;
  logic       was_done;
  logic       push, push_ok, clr, fin, close_key, close_val, close_ident;
  logic [7:0] push_c;
  status_e    fin_v;

  assign c          = in_item_i.in_byte;
  assign in_stall_o = q_full_i || burst_out_q;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin : next_state
    if (in_item_i.restart) begin
      st   = PsStart;
      qc   = 8'h00;
      prev = 8'h00;
      esc  = 1'b0;
      kk   = KindNone;
      ln   = '0;
      ov   = 1'b0;
      vd   = StUndecided;
      dok  = 1'b1;
      eok  = 1'b1;
    end else begin
      st   = state_q;
      qc   = quote_q;
      prev = prev_q;
      esc  = esc_q;
      kk   = kind_q;
      ln   = len_q;
      ov   = ovf_q;
      vd   = verdict_q;
      dok  = dok_q;
      eok  = eok_q;
    end

    state_d     = st;
    quote_d     = qc;
    prev_d      = prev;
    esc_d       = esc;
    kind_d      = kk;
    push        = 1'b0;
    push_c      = c;
    clr         = 1'b0;
    fin         = 1'b0;
    fin_v       = StUndecided;
    close_key   = 1'b0;
    close_val   = 1'b0;
    close_ident = 1'b0;
    was_done    = (st == PsDone);

    if (!was_done) begin
      if (c == CharDot && prev == CharLf) begin
        fin   = 1'b1;
        fin_v = StNotJson;
      end else begin
        prev_d = c;
        case (st)
          PsStart: begin
            if (c == CharLBrace) begin
              clr     = 1'b1;
              state_d = PsHdr;
            end else if (!is_space(c)) begin
              fin   = 1'b1;
              fin_v = StNotJson;
            end
          end
          PsHdr: begin
            if (!is_space(c)) begin
              if (c == CharDquote || c == CharSquote) begin
                quote_d = c;
                state_d = PsSkeyDash;
              end else if (c == CharDash) begin
                state_d = PsIkey;
              end else if (is_alpha(c)) begin
                push    = 1'b1;
                push_c  = to_lower(c);
                state_d = PsIkey;
              end else begin
                fin   = 1'b1;
                fin_v = StNotJson;
              end
            end
          end
          PsSkeyDash: begin
            if (c == qc) begin
              quote_d = 8'h00;
              state_d = PsSeekAssign;
            end else if (c == CharBslash) begin
              state_d = PsSkey;
              esc_d   = 1'b1;
            end else if (c == CharDash) begin
              state_d = PsSkey;
            end else begin
              push = 1'b1;
            end
          end
          PsSkey: begin
            if (esc) begin
              push  = 1'b1;
              esc_d = 1'b0;
            end else if (c == qc) begin
              quote_d = 8'h00;
              state_d = PsSeekAssign;
            end else if (c == CharBslash) begin
              esc_d = 1'b1;
            end else begin
              push = 1'b1;
            end
          end
          PsIkey: begin
            if (is_alnum(c)) begin
              push   = 1'b1;
              push_c = to_lower(c);
            end else if (is_space(c)) begin
              state_d = PsSeekAssign;
            end else if (c == CharColon) begin
              close_key = 1'b1;
            end else begin
              fin   = 1'b1;
              fin_v = StNotJson;
            end
          end
          PsSeekAssign: begin
            if (!is_space(c)) begin
              if (c == CharColon) begin
                close_key = 1'b1;
              end else begin
                fin   = 1'b1;
                fin_v = StNotJson;
              end
            end
          end
          PsAssign: begin
            if (!is_space(c)) begin
              if (c == CharDquote || c == CharSquote) begin
                quote_d = c;
                state_d = PsSval;
              end else if (is_alnum(c)) begin
                push    = 1'b1;
                push_c  = to_lower(c);
                state_d = PsIval;
              end else begin
                fin   = 1'b1;
                fin_v = StSyntax;
              end
            end
          end
          PsSval: begin
            if (esc) begin
              push  = 1'b1;
              esc_d = 1'b0;
            end else if (c == qc) begin
              quote_d   = 8'h00;
              close_val = 1'b1;
            end else if (c == CharBslash) begin
              esc_d = 1'b1;
            end else begin
              push = 1'b1;
            end
          end
          PsIval: begin
            if (is_space(c) || c == CharComma || c == CharRBrace) begin
              close_val   = 1'b1;
              close_ident = 1'b1;
            end else begin
              push   = 1'b1;
              push_c = to_lower(c);
            end
          end
          PsSeekDelim: begin
            if (!is_space(c)) begin
              if (c == CharComma) begin
                state_d = PsHdr;
              end else begin
                fin   = 1'b1;
                fin_v = StNotJson;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (close_key) begin
      clr = 1'b1;
      if (dok && !ov && ln == LenW'(DoctypeLen)) begin
        kind_d  = KindDoctype;
        state_d = PsAssign;
      end else if (eok && !ov && ln == LenW'(EncodingLen)) begin
        kind_d  = KindEncoding;
        state_d = PsAssign;
      end else begin
        kind_d = KindNone;
        fin    = 1'b1;
        fin_v  = StNoDoc;
      end
    end

    if (close_val) begin
      if (kk == KindDoctype) begin
        kind_d = KindNone;
        fin    = 1'b1;
        fin_v  = StDoctype;
      end else begin
        clr = 1'b1;
        if (kk == KindEncoding) begin
          if (!close_ident || is_space(c)) begin
            state_d = PsSeekDelim;
          end else if (c == CharComma) begin
            state_d = PsHdr;
          end else begin
            fin   = 1'b1;
            fin_v = StNotJson;
          end
        end else begin
          fin   = 1'b1;
          fin_v = StSyntax;
        end
      end
    end

    len_d   = ln;
    ovf_d   = ov;
    dok_d   = dok;
    eok_d   = eok;
    push_ok = push && (ln < LenW'(BufDepth));
    if (push) begin
      if (push_ok) begin
        len_d = ln + LenW'(1);
        dok_d = dok && (ln < LenW'(DoctypeLen))
                && (to_lower(push_c) == doctype_char(ln[2:0]));
        eok_d = eok && (ln < LenW'(EncodingLen))
                && (to_lower(push_c) == encoding_char(ln[2:0]));
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (clr) begin
      len_d = '0;
      ovf_d = 1'b0;
      dok_d = 1'b1;
      eok_d = 1'b1;
    end

    verdict_d = vd;
    if (fin) begin
      state_d   = PsDone;
      verdict_d = fin_v;
    end
  end

  always_comb begin : outputs
    q_push_o        = accept;
    q_cmd_o.burst   = !was_done && fin && (fin_v == StDoctype);
    q_cmd_o.status  = (state_d == PsDone) ? verdict_d : StUndecided;
    q_cmd_o.len     = len_d;
    q_cmd_o.trunc   = ovf_d;
    mem_wr_o.en     = accept && push_ok;
    mem_wr_o.addr   = ln[AddrW-1:0];
    mem_wr_o.data   = push_c;
    burst_out_d     = burst_out_q;
    if (burst_done_i) begin
      burst_out_d = 1'b0;
    end
    if (accept && q_cmd_o.burst) begin
      burst_out_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PsStart;
      quote_q     <= 8'h00;
      prev_q      <= 8'h00;
      esc_q       <= 1'b0;
      kind_q      <= KindNone;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      verdict_q   <= StUndecided;
      dok_q       <= 1'b1;
      eok_q       <= 1'b1;
      burst_out_q <= 1'b0;
    end else begin
      burst_out_q <= burst_out_d;
      if (accept) begin
        state_q   <= state_d;
        quote_q   <= quote_d;
        prev_q    <= prev_d;
        esc_q     <= esc_d;
        kind_q    <= kind_d;
        len_q     <= len_d;
        ovf_q     <= ovf_d;
        verdict_q <= verdict_d;
        dok_q     <= dok_d;
        eok_q     <= eok_d;
      end
    end
  end

  `JHDD_ASSERT_IMPLIES(a_len_bounded, 1'b1, len_q <= LenW'(BufDepth), "capture length overran")
  `JHDD_ASSERT_IMPLIES(a_ovf_only_full, ovf_q, len_q == LenW'(BufDepth), "overflow below full")
  `JHDD_ASSERT_NEXT(a_burst_blocks_input, q_push_o && q_cmd_o.burst, in_stall_o, "input open in run")

endmodule

/* rtl/core/jhdd_queue.sv */
// Short command queue between the front and back of the doctype detector.
// Depends on jhdd_pkg.
module jhdd_queue import jhdd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t             ent_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/jhdd_back.sv */
// Back end of the doctype detector: value store, result sequencing and the
// output register. Depends on jhdd_pkg and the macro header.
`include "json_header_doctype_detector_macros.svh"

module jhdd_back import jhdd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  input  mem_wr_t   mem_wr_i,
  output logic      burst_done_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [7:0]       mem_q [BufDepth];
  logic [7:0]       rd_data_q;
  back_state_e      bst_q, bst_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             trunc_q, trunc_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;

  logic             slot_free, is_last, load, rd_en;
  logic [AddrW-1:0] rd_addr;
  out_item_t        load_item;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign is_last   = (LenW'(idx_q) + LenW'(1)) == len_q;

  always_comb begin : next_state
    bst_d   = bst_q;
    idx_d   = idx_q;
    len_d   = len_q;
    trunc_d = trunc_q;
    case (bst_q)
      BkIdle: begin
        if (q_valid_i && slot_free && q_cmd_i.burst && q_cmd_i.len != '0) begin
          bst_d   = BkBurst;
          idx_d   = '0;
          len_d   = q_cmd_i.len;
          trunc_d = q_cmd_i.trunc;
        end
      end
      BkBurst: begin
        if (slot_free) begin
          if (is_last) begin
            bst_d = BkIdle;
          end else begin
            idx_d = idx_q + AddrW'(1);
          end
        end
      end
      default: bst_d = BkIdle;
    endcase
  end

  always_comb begin : outputs
    q_pop_o      = 1'b0;
    load         = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    burst_done_o = 1'b0;
    load_item    = '{status: q_cmd_i.status, value_byte: 8'h00, value_valid: 1'b0,
                     last_of_run: 1'b1, value_truncated: 1'b0};
    case (bst_q)
      BkIdle: begin
        if (q_valid_i && slot_free) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.burst) begin
            if (q_cmd_i.len == '0) begin
              load                      = 1'b1;
              burst_done_o              = 1'b1;
              load_item.status          = StDoctype;
              load_item.value_truncated = q_cmd_i.trunc;
            end else begin
              rd_en = 1'b1;
            end
          end else begin
            load = 1'b1;
          end
        end
      end
      BkBurst: begin
        if (slot_free) begin
          load      = 1'b1;
          load_item = '{status: StDoctype, value_byte: rd_data_q, value_valid: 1'b1,
                        last_of_run: is_last, value_truncated: trunc_q};
          if (is_last) begin
            burst_done_o = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q + AddrW'(1);
          end
        end
      end
      default: begin
      end
    endcase
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (load) begin
      out_q <= load_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_q       <= BkIdle;
      idx_q       <= '0;
      len_q       <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bst_q       <= bst_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      trunc_q     <= trunc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `JHDD_ASSERT_IMPLIES(a_pop_has_entry, q_pop_o, q_valid_i, "pop from empty queue")
  `JHDD_ASSERT_IMPLIES(a_idx_in_range, bst_q == BkBurst, LenW'(idx_q) < len_q, "run index out of range")
  `JHDD_ASSERT_NEXT(a_done_to_idle, burst_done_o, bst_q == BkIdle, "run end left sequencer busy")

endmodule

/* rtl/core/json_header_doctype_detector.sv */
// JSON header doctype detector: one byte per transfer, one status per byte, a run for a doctype.
// Each status passes the command queue and output register; one byte per cycle when not stalled.
// Doctype found: value bytes from a registered store read, one per unstalled cycle; input held.
// Reset is asynchronous, active low; it clears control state, the value store is not cleared.
// Depends on jhdd_pkg, jhdd_front, jhdd_queue and jhdd_back.
module json_header_doctype_detector import jhdd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic    q_full, q_push, q_valid, q_pop, burst_done;
  cmd_t    cmd_in, cmd_out;
  mem_wr_t mem_wr;

  jhdd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (cmd_in),
    .mem_wr_o     (mem_wr),
    .burst_done_i (burst_done)
  );

  jhdd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (cmd_out)
  );

  jhdd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (cmd_out),
    .q_pop_o      (q_pop),
    .mem_wr_i     (mem_wr),
    .burst_done_o (burst_done),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

/* tb/tb_json_header_doctype_detector.sv */
// Self-checking testbench for json_header_doctype_detector, one byte per input transfer.
// Short scripted documents, then random headers, checked against a predictor of the recognizer.
// Depends on jhdd_pkg and the json_header_doctype_detector RTL.
module tb_json_header_doctype_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import jhdd_pkg::*;

  typedef struct packed {
    in_item_t item;
    logic     fixed;
    status_e  status;
  } script_row_t;

  localparam int unsigned ScriptLen = 23;
  localparam int unsigned ByteTarget = 260;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  in_item_t  in_item_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  int unsigned idle_pct = 20;
  int unsigned mismatches = 0;

  parse_state_e hdr_state = PsStart;
  logic [7:0]   hdr_quote = '0;
  logic [7:0]   hdr_prev = '0;
  logic         hdr_esc = 1'b0;
  key_kind_e    hdr_kind = KindNone;
  logic [7:0]   hdr_buf [BufDepth];
  int unsigned  hdr_len = 0;
  logic         hdr_ovf = 1'b0;
  status_e      hdr_verdict = StUndecided;

  out_item_t byte_results [$];
  out_item_t header_results [$];
  out_item_t head;

  script_row_t script [ScriptLen] = '{
    '{'{CharLBrace, 1'b1}, 1'b1, StUndecided},
    '{'{CharSpace, 1'b0}, 1'b0, StUndecided},
    '{'{"D", 1'b0}, 1'b0, StUndecided},
    '{'{"o", 1'b0}, 1'b0, StUndecided},
    '{'{"C", 1'b0}, 1'b0, StUndecided},
    '{'{"t", 1'b0}, 1'b0, StUndecided},
    '{'{"y", 1'b0}, 1'b0, StUndecided},
    '{'{"p", 1'b0}, 1'b0, StUndecided},
    '{'{"e", 1'b0}, 1'b0, StUndecided},
    '{'{CharColon, 1'b0}, 1'b0, StUndecided},
    '{'{CharRBrace, 1'b0}, 1'b1, StSyntax},
    '{'{"x", 1'b0}, 1'b1, StSyntax},
    '{'{8'hFF, 1'b1}, 1'b1, StNotJson},
    '{'{8'h01, 1'b1}, 1'b1, StUndecided},
    '{'{CharLf, 1'b0}, 1'b0, StUndecided},
    '{'{CharDot, 1'b0}, 1'b1, StNotJson},
    '{'{CharLBrace, 1'b1}, 1'b1, StUndecided},
    '{'{"k", 1'b0}, 1'b0, StUndecided},
    '{'{CharColon, 1'b0}, 1'b1, StNoDoc},
    '{'{CharLBrace, 1'b1}, 1'b0, StUndecided},
    '{'{CharDquote, 1'b0}, 1'b0, StUndecided},
    '{'{CharDquote, 1'b0}, 1'b0, StUndecided},
    '{'{CharColon, 1'b0}, 1'b1, StNoDoc}
  };

  json_header_doctype_detector i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic letter(input logic [7:0] c);
    logic [7:0] l;
    l = fold(c);
    return (l >= "a" && l <= "z") || c == CharUscore;
  endfunction

  function automatic logic alnum(input logic [7:0] c);
    return letter(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return c <= CharSpace;
  endfunction

  function automatic void store_char(input logic [7:0] c);
    if (hdr_len < BufDepth) begin
      hdr_buf[hdr_len] = c;
      hdr_len++;
    end else begin
      hdr_ovf = 1'b1;
    end
  endfunction

  function automatic void settle(input status_e v);
    hdr_state = PsDone;
    hdr_verdict = v;
  endfunction

  function automatic logic key_is(input string w);
    if (hdr_ovf || hdr_len != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) begin
      if (fold(hdr_buf[i]) != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void close_key();
    if (key_is("doctype")) begin
      hdr_kind = KindDoctype;
      hdr_state = PsAssign;
    end else if (key_is("encoding")) begin
      hdr_kind = KindEncoding;
      hdr_state = PsAssign;
    end else begin
      hdr_kind = KindNone;
      settle(StNoDoc);
    end
    hdr_len = 0;
    hdr_ovf = 1'b0;
  endfunction

  function automatic void close_value(input logic [7:0] c, input logic bare);
    if (hdr_kind == KindDoctype) begin
      hdr_kind = KindNone;
      settle(StDoctype);
      return;
    end
    if (hdr_kind == KindEncoding) begin
      if (!bare || blank(c)) hdr_state = PsSeekDelim;
      else if (c == CharComma) hdr_state = PsHdr;
      else settle(StNotJson);
    end else begin
      settle(StSyntax);
    end
    hdr_len = 0;
    hdr_ovf = 1'b0;
  endfunction

  function automatic void step_parser(input logic [7:0] c);
    case (hdr_state)
      PsStart: begin
        if (c == CharLBrace) begin
          hdr_len = 0;
          hdr_ovf = 1'b0;
          hdr_state = PsHdr;
        end else if (!blank(c)) begin
          settle(StNotJson);
        end
      end
      PsHdr: begin
        if (blank(c)) begin
        end else if (c == CharDquote || c == CharSquote) begin
          hdr_quote = c;
          hdr_state = PsSkeyDash;
        end else if (c == CharDash) begin
          hdr_state = PsIkey;
        end else if (letter(c)) begin
          store_char(fold(c));
          hdr_state = PsIkey;
        end else begin
          settle(StNotJson);
        end
      end
      PsSkeyDash: begin
        if (c == hdr_quote) begin
          hdr_quote = '0;
          hdr_state = PsSeekAssign;
        end else if (c == CharBslash) begin
          hdr_state = PsSkey;
          hdr_esc = 1'b1;
        end else if (c == CharDash) begin
          hdr_state = PsSkey;
        end else begin
          store_char(c);
        end
      end
      PsSkey: begin
        if (hdr_esc) begin
          store_char(c);
          hdr_esc = 1'b0;
        end else if (c == hdr_quote) begin
          hdr_quote = '0;
          hdr_state = PsSeekAssign;
        end else if (c == CharBslash) begin
          hdr_esc = 1'b1;
        end else begin
          store_char(c);
        end
      end
      PsIkey: begin
        if (alnum(c)) store_char(fold(c));
        else if (blank(c)) hdr_state = PsSeekAssign;
        else if (c == CharColon) close_key();
        else settle(StNotJson);
      end
      PsSeekAssign: begin
        if (blank(c)) begin
        end else if (c == CharColon) begin
          close_key();
        end else begin
          settle(StNotJson);
        end
      end
      PsAssign: begin
        if (blank(c)) begin
        end else if (c == CharDquote || c == CharSquote) begin
          hdr_quote = c;
          hdr_state = PsSval;
        end else if (alnum(c)) begin
          store_char(fold(c));
          hdr_state = PsIval;
        end else begin
          settle(StSyntax);
        end
      end
      PsSval: begin
        if (hdr_esc) begin
          store_char(c);
          hdr_esc = 1'b0;
        end else if (c == hdr_quote) begin
          hdr_quote = '0;
          close_value(c, 1'b0);
        end else if (c == CharBslash) begin
          hdr_esc = 1'b1;
        end else begin
          store_char(c);
        end
      end
      PsIval: begin
        if (blank(c) || c == CharComma || c == CharRBrace) close_value(c, 1'b1);
        else store_char(fold(c));
      end
      PsSeekDelim: begin
        if (blank(c)) begin
        end else if (c == CharComma) begin
          hdr_state = PsHdr;
        end else begin
          settle(StNotJson);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void scan_header_byte(input in_item_t it);
    logic [7:0] c;
    logic       was_done;
    c = it.in_byte;
    byte_results = {};
    if (it.restart) begin
      hdr_state = PsStart;
      hdr_quote = '0;
      hdr_prev = '0;
      hdr_esc = 1'b0;
      hdr_kind = KindNone;
      hdr_len = 0;
      hdr_ovf = 1'b0;
      hdr_verdict = StUndecided;
    end
    was_done = hdr_state == PsDone;
    if (!was_done) begin
      if (c == CharDot && hdr_prev == CharLf) begin
        settle(StNotJson);
      end else begin
        hdr_prev = c;
        step_parser(c);
      end
    end
    if (!was_done && hdr_state == PsDone && hdr_verdict == StDoctype) begin
      if (hdr_len == 0) begin
        byte_results.insert(byte_results.size(),
                            out_item_t'{StDoctype, 8'h00, 1'b0, 1'b1, hdr_ovf});
      end else begin
        for (int i = 0; i < hdr_len; i++) begin
          byte_results.insert(byte_results.size(),
                              out_item_t'{StDoctype, hdr_buf[i], 1'b1,
                                          logic'(i + 1 == hdr_len), hdr_ovf});
        end
      end
    end else begin
      byte_results.insert(byte_results.size(),
                          out_item_t'{(hdr_state == PsDone) ? hdr_verdict : StUndecided,
                                      8'h00, 1'b0, 1'b1, 1'b0});
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [7:0] pick_space();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(1, 31)) : CharSpace;
  endfunction

  function automatic logic [7:0] any_case(input logic [7:0] c);
    return (c >= "a" && c <= "z" && $urandom_range(1) == 1) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] word_char();
    int unsigned sel;
    sel = $urandom_range(62);
    if (sel < 26) return 8'("a" + sel);
    if (sel < 52) return 8'("A" + sel - 26);
    if (sel < 62) return 8'("0" + sel - 52);
    return CharUscore;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] marks [10] = '{CharLBrace, CharRBrace, CharColon, CharComma, CharDquote,
                               CharSquote, CharBslash, CharDash, CharDot, CharLf};
    if ($urandom_range(1) == 1) return 8'($urandom_range(1, 255));
    return marks[$urandom_range(9)];
  endfunction

  task automatic drive_byte(input in_item_t it, input logic fixed, input status_e status);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    scan_header_byte(it);
    if (fixed) begin
      header_results.insert(header_results.size(),
                            out_item_t'{status, 8'h00, 1'b0, 1'b1, 1'b0});
    end else begin
      foreach (byte_results[i]) header_results.insert(header_results.size(), byte_results[i]);
    end
    @(negedge clk_i);
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (header_results.size() == 0) begin
        $error("result with none pending: status %0d", out_item_o.status);
        mismatches++;
      end else begin
        head = header_results.pop_front();
        check_field("status", head.status, out_item_o.status);
        check_field("value_byte", head.value_byte, out_item_o.value_byte);
        check_field("value_valid", head.value_valid, out_item_o.value_valid);
        check_field("last_of_run", head.last_of_run, out_item_o.last_of_run);
        check_field("value_truncated", head.value_truncated, out_item_o.value_truncated);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0]  doc [$];
    logic [7:0]  key [$];
    logic [7:0]  qc;
    logic [7:0]  ch;
    logic [7:0]  delim;
    string       name;
    int unsigned counted;
    int unsigned pairs;
    int unsigned pick;
    int unsigned vlen;
    int unsigned pos;
    logic        rs;

    counted = ScriptLen;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) drive_byte(script[i].item, script[i].fixed, script[i].status);

    while (counted < ByteTarget) begin
      idle_pct = (counted >= 100 && counted < 160) ? 0 : 20;
      doc = {};
      repeat ($urandom_range(0, 1)) doc = {doc, pick_space()};
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 6)) doc = {doc, noise_byte()};
      end else begin
        doc = {doc, CharLBrace};
        pairs = $urandom_range(1, 3);
        for (int p = 0; p < pairs; p++) begin
          repeat ($urandom_range(0, 2)) doc = {doc, pick_space()};
          key = {};
          pick = $urandom_range(99);
          if (pick < 88 && pick >= 75) begin
            repeat ($urandom_range(1, 9)) key = {key, word_char()};
          end else begin
            name = (pick < 40) ? "doctype" : (pick < 75) ? "encoding" :
                   "doctype_with_a_key_far_too_long_to_fit";
            for (int i = 0; i < name.len(); i++) key = {key, any_case(name[i])};
          end
          pick = $urandom_range(2);
          if (pick == 0) begin
            if ($urandom_range(9) == 0) doc = {doc, CharDash};
            foreach (key[i]) doc = {doc, key[i]};
          end else begin
            qc = (pick == 1) ? CharDquote : CharSquote;
            doc = {doc, qc};
            foreach (key[i]) begin
              if ($urandom_range(9) == 0) doc = {doc, CharDash};
              if ($urandom_range(14) == 0) doc = {doc, CharBslash};
              doc = {doc, key[i]};
            end
            doc = {doc, qc};
          end
          repeat ($urandom_range(0, 1)) doc = {doc, pick_space()};
          doc = {doc, CharColon};
          repeat ($urandom_range(0, 2)) doc = {doc, pick_space()};
          vlen = ($urandom_range(99) < 8) ? $urandom_range(28, 40) : $urandom_range(0, 6);
          delim = (p == pairs - 1) ? CharRBrace : CharComma;
          if ($urandom_range(19) == 0) delim = noise_byte();
          pick = $urandom_range(9);
          if (pick < 5) begin
            qc = ($urandom_range(1) == 1) ? CharDquote : CharSquote;
            doc = {doc, qc};
            repeat (vlen) begin
              ch = 8'($urandom_range(1, 255));
              if (ch == qc || ch == CharBslash || $urandom_range(9) == 0) begin
                doc = {doc, CharBslash};
              end
              doc = {doc, ch};
            end
            doc = {doc, qc};
          end else if (pick < 9) begin
            doc = {doc, any_case(word_char())};
            repeat ((vlen > 0) ? vlen - 1 : 0) begin
              ch = 8'($urandom_range(1, 255));
              if (blank(ch) || ch == CharComma || ch == CharRBrace) ch = word_char();
              doc = {doc, ch};
            end
          end else begin
            doc = {doc, noise_byte()};
          end
          if ($urandom_range(1) == 1) doc = {doc, pick_space()};
          doc = {doc, delim};
        end
      end
      if ($urandom_range(24) == 0) begin
        pos = $urandom_range(doc.size());
        doc.insert(pos, CharDot);
        doc.insert(pos, CharLf);
      end
      foreach (doc[i]) begin
        rs = (i == 0) || ($urandom_range(99) == 0);
        counted++;
        drive_byte('{doc[i], rs}, 1'b0, StUndecided);
      end
    end

    in_valid_i <= 1'b0;
    while (header_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/jhdd_pkg.sv
rtl/core/jhdd_front.sv
rtl/core/jhdd_queue.sv
rtl/core/jhdd_back.sv
rtl/core/json_header_doctype_detector.sv
tb/tb_json_header_doctype_detector.sv
